// ===== sv/tpd_pkg.sv =====
// Package for the track polyline distance table: widths, defaults and helpers.
// Used by tpd_ctrl, tpd_dp and track_polyline_distance_table_core.
package tpd_pkg;

    localparam int MAX_NODES_DEF     = 64;
    localparam int POS_FRAC_BITS_DEF = 6;
    localparam int POS_W    = 24;
    localparam int QUANT_W  = 16;
    localparam int DIST_W   = 16;
    localparam int TOTAL_W  = 32;
    localparam int CNT_W    = 7;
    localparam int IDX_W    = 6;
    localparam int SQ_W     = 52;   // dx*dx + dy*dy fits in 49 bits
    localparam int ROOT_W   = 26;
    localparam int ACC_W    = 40;   // 64 segments of at most 2^26

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

    typedef enum logic [0:0] {
        REQ_STORE   = 1'b0,
        REQ_PUBLISH = 1'b1
    } req_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic             write_node;  // store the accepted word's position
        logic             clear_acc;   // start a new distance sum
        logic             seg_load;    // load the segment between rd_a and rd_b
        logic             seg_add;     // add the finished root to the sum
        logic             latch_total; // capture the closing sum as the total
        logic             emit;        // load the output register
        logic             emit_err;    // emit an error word
        logic             emit_last;   // mark the emitted word last
        logic [IDX_W-1:0] rd_a;
        logic [IDX_W-1:0] rd_b;
    } tpd_cmd_t;

    typedef struct packed {
        logic seg_done;
        logic out_busy;
    } tpd_sts_t;

endpackage

// ===== sv/tpd_dp.sv =====
// Datapath: node store, segment length by iterative square root, sum,
// quantizers and the output register. Depends on tpd_pkg.
module tpd_dp #(
    parameter int MAX_NODES     = tpd_pkg::MAX_NODES_DEF,
    parameter int POS_FRAC_BITS = tpd_pkg::POS_FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tpd_pkg::tpd_cmd_t               cmd,
    output tpd_pkg::tpd_sts_t               sts,
    input  logic [tpd_pkg::IDX_W-1:0]       in_index,
    input  logic signed [tpd_pkg::POS_W-1:0] in_x,
    input  logic signed [tpd_pkg::POS_W-1:0] in_y,
    input  logic signed [tpd_pkg::POS_W-1:0] in_z,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tpd_pkg::IDX_W-1:0]       m_out_index,
    output logic signed [tpd_pkg::QUANT_W-1:0] m_quant_x,
    output logic signed [tpd_pkg::QUANT_W-1:0] m_quant_y,
    output logic signed [tpd_pkg::QUANT_W-1:0] m_quant_z,
    output logic [tpd_pkg::DIST_W-1:0]      m_rail_distance,
    output logic [tpd_pkg::TOTAL_W-1:0]     m_total_length,
    output logic                            m_status,
    output logic                            m_last
);
    localparam int PW = tpd_pkg::POS_W;
    localparam int SH = POS_FRAC_BITS - 3;
    localparam int AW = $clog2(MAX_NODES);
    localparam int SQW = tpd_pkg::SQ_W;
    localparam int RW = tpd_pkg::ROOT_W;
    localparam int ACW = tpd_pkg::ACC_W;
    localparam int STEPS = SQW / 2;

    // Node store with a valid bit per entry; an invalid entry reads as zero.
    logic [PW-1:0] x_mem [MAX_NODES];
    logic [PW-1:0] y_mem [MAX_NODES];
    logic [PW-1:0] z_mem [MAX_NODES];
    logic [MAX_NODES-1:0] vld_reg;
    logic [PW-1:0] ax_reg, ay_reg, bx_reg, by_reg, az_reg;
    logic          av_reg, bv_reg;

    always_ff @(posedge aclk) begin
        if (cmd.write_node) begin
            x_mem[in_index[AW-1:0]] <= in_x;
            y_mem[in_index[AW-1:0]] <= in_y;
            z_mem[in_index[AW-1:0]] <= in_z;
        end
        ax_reg <= x_mem[cmd.rd_a[AW-1:0]];
        ay_reg <= y_mem[cmd.rd_a[AW-1:0]];
        az_reg <= z_mem[cmd.rd_a[AW-1:0]];
        bx_reg <= x_mem[cmd.rd_b[AW-1:0]];
        by_reg <= y_mem[cmd.rd_b[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            av_reg  <= 1'b0;
            bv_reg  <= 1'b0;
        end else begin
            if (cmd.write_node) vld_reg[in_index[AW-1:0]] <= 1'b1;
            av_reg <= vld_reg[cmd.rd_a[AW-1:0]];
            bv_reg <= vld_reg[cmd.rd_b[AW-1:0]];
        end
    end

    logic signed [PW-1:0] xa, ya, za, xb, yb;
    assign xa = av_reg ? ax_reg : '0;
    assign ya = av_reg ? ay_reg : '0;
    assign za = av_reg ? az_reg : '0;
    assign xb = bv_reg ? bx_reg : '0;
    assign yb = bv_reg ? by_reg : '0;

    // Segment: absolute deltas, squares, then a bit-pair-per-cycle root.
    logic signed [PW:0] dx, dy;
    logic [PW-1:0]      mx, my;
    assign dx = {xa[PW-1], xa} - {xb[PW-1], xb};
    assign dy = {ya[PW-1], ya} - {yb[PW-1], yb};
    assign mx = dx[PW] ? PW'(-dx) : dx[PW-1:0];
    assign my = dy[PW] ? PW'(-dy) : dy[PW-1:0];

    typedef enum logic [1:0] {S_IDLE, S_DELTA, S_SQ, S_ROOT} seg_t;
    seg_t seg_reg;
    logic [PW-1:0]  mx_reg, my_reg;
    logic [2*PW-1:0] sqx_reg, sqy_reg;
    logic [SQW-1:0] rem_reg;
    logic [RW-1:0]  root_reg;
    logic [$clog2(STEPS+1)-1:0] step_reg;
    logic           done_reg;

    logic [SQW-1:0] rem_sh;
    logic [RW+1:0]  trial;
    // Restoring square root: bring down two bits, try 4*root+1.
    logic [RW+1:0] cur;
    logic [RW+1:0] part_reg;
    assign cur   = {part_reg[RW-1:0], rem_reg[SQW-1 -: 2]};
    assign trial = {root_reg, 2'b01};
    assign rem_sh = {rem_reg[SQW-3:0], 2'b00};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg  <= S_IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (seg_reg)
                S_IDLE: if (cmd.seg_load) seg_reg <= S_DELTA;
                S_DELTA: begin
                    mx_reg  <= mx;
                    my_reg  <= my;
                    seg_reg <= S_SQ;
                end
                S_SQ: begin
                    sqx_reg  <= mx_reg * mx_reg;
                    sqy_reg  <= my_reg * my_reg;
                    step_reg <= '0;
                    seg_reg  <= S_ROOT;
                end
                S_ROOT: begin
                    if (step_reg == '0) begin
                        rem_reg  <= SQW'(sqx_reg) + SQW'(sqy_reg);
                        root_reg <= '0;
                        part_reg <= '0;
                        step_reg <= step_reg + 1'b1;
                    end else begin
                        if (cur >= trial) begin
                            part_reg <= cur - trial;
                            root_reg <= {root_reg[RW-2:0], 1'b1};
                        end else begin
                            part_reg <= cur;
                            root_reg <= {root_reg[RW-2:0], 1'b0};
                        end
                        rem_reg <= rem_sh;
                        if (step_reg == ($clog2(STEPS+1))'(STEPS)) begin
                            seg_reg  <= S_IDLE;
                            done_reg <= 1'b1;
                        end else begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                end
                default: seg_reg <= S_IDLE;
            endcase
        end
    end
    assign sts.seg_done = done_reg;

    // Distance sum; root_reg holds the last finished segment.
    logic [ACW-1:0] acc_reg;
    logic [tpd_pkg::TOTAL_W-1:0] total_reg;
    always_ff @(posedge aclk) begin
        if (cmd.clear_acc)    acc_reg <= '0;
        else if (cmd.seg_add) acc_reg <= acc_reg + ACW'(root_reg);
        if (cmd.latch_total)
            total_reg <= (acc_reg[ACW-1:tpd_pkg::TOTAL_W] != '0) ? '1
                         : acc_reg[tpd_pkg::TOTAL_W-1:0];
    end

    function automatic logic [tpd_pkg::QUANT_W-1:0] quant(input logic signed [PW-1:0] v);
        logic [PW-1:0] mag;
        logic [PW-1:0] q;
        mag = v[PW-1] ? PW'(-v) : v;
        q = PW'(({1'b0, mag} + (PW+1)'(1 << (SH-1))) >> SH);
        if (!v[PW-1]) quant = (q > PW'(32767)) ? 16'h7FFF : q[15:0];
        else          quant = (q > PW'(32768)) ? 16'h8000 : 16'(-q);
    endfunction

    logic [ACW+1:0] d3;
    logic [ACW+1:0] dq;
    assign d3 = ({2'b00, acc_reg} << 1) + {2'b00, acc_reg} + (ACW+2)'(1 << (POS_FRAC_BITS-1));
    assign dq = d3 >> POS_FRAC_BITS;

    logic mv_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) mv_reg <= 1'b0;
        else if (cmd.emit) mv_reg <= 1'b1;
        else if (m_ready) mv_reg <= 1'b0;
    end
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_last <= cmd.emit_last;
            m_out_index <= cmd.rd_a;
            if (cmd.emit_err) begin
                m_quant_x <= '0; m_quant_y <= '0; m_quant_z <= '0;
                m_rail_distance <= '0; m_total_length <= '0; m_status <= 1'b1;
            end else begin
                m_quant_x <= quant(xa);
                m_quant_y <= quant(ya);
                m_quant_z <= quant(za);
                m_rail_distance <= (dq[ACW+1:16] != '0) ? 16'hFFFF : dq[15:0];
                m_total_length <= total_reg;
                m_status <= 1'b0;
            end
        end
    end
    assign m_valid = mv_reg;
    assign sts.out_busy = mv_reg && !m_ready;
endmodule

// ===== sv/tpd_ctrl.sv =====
// Controller: accepts words, sequences the two publish passes over the nodes.
// Depends on tpd_pkg; drives tpd_dp through tpd_cmd_t.
module tpd_ctrl #(
    parameter int MAX_NODES = tpd_pkg::MAX_NODES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_req_type,
    input  logic [tpd_pkg::IDX_W-1:0]   s_node_index,
    input  logic [tpd_pkg::CNT_W-1:0]   node_count,
    input  tpd_pkg::tpd_sts_t           sts,
    output tpd_pkg::tpd_cmd_t           cmd
);
    localparam int IW = tpd_pkg::IDX_W;
    localparam int CW = tpd_pkg::CNT_W;

    typedef enum logic [3:0] {
        C_IDLE, C_ERR, C_SUM_RD, C_SUM_WAIT, C_CLOSE_RD, C_CLOSE_WAIT,
        C_OUT_RD, C_OUT_WAIT, C_OUT_EMIT
    } st_t;
    st_t st_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] eff;
    assign eff = (node_count > CW'(MAX_NODES)) ? CW'(MAX_NODES) : node_count;

    logic acc;
    assign s_ready = (st_reg == C_IDLE) && !sts.out_busy;
    assign acc = s_valid && s_ready;

    // Node 0 pairs with itself, so its segment adds nothing.
    logic [IW-1:0] prev;
    assign prev = (i_reg == '0) ? '0 : IW'(i_reg - 1'b1);

    // Latch the total in the cycle after the closing segment is added, and
    // restart the sum for the emit pass on the same edge.
    logic lat_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) lat_reg <= 1'b0;
        else          lat_reg <= (st_reg == C_CLOSE_WAIT) && sts.seg_done;
    end

    always_comb begin
        cmd = '0;
        cmd.rd_a = i_reg[IW-1:0];
        cmd.rd_b = prev;
        cmd.latch_total = lat_reg;
        cmd.clear_acc   = lat_reg;
        case (st_reg)
            C_IDLE: begin
                cmd.write_node = acc && (CW'(s_node_index) < eff);
                cmd.clear_acc  = 1'b1;
            end
            C_ERR: begin
                cmd.emit = 1'b1; cmd.emit_err = 1'b1; cmd.emit_last = 1'b1;
            end
            C_SUM_RD, C_OUT_RD: cmd.seg_load = 1'b1;
            C_SUM_WAIT, C_OUT_WAIT: cmd.seg_add = sts.seg_done;
            C_CLOSE_RD: begin
                cmd.rd_a = IW'(cnt_reg - 1'b1);
                cmd.rd_b = '0;
                cmd.seg_load = 1'b1;
            end
            C_CLOSE_WAIT: begin
                cmd.rd_a = '0;
                cmd.seg_add = sts.seg_done;
            end
            C_OUT_EMIT: begin
                cmd.emit = !sts.out_busy;
                cmd.emit_last = (i_reg + 1'b1) == cnt_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= C_IDLE;
            cnt_reg <= '0;
            i_reg   <= '0;
        end else begin
            case (st_reg)
                C_IDLE: if (acc) begin
                    cnt_reg <= eff;
                    // An out-of-range index is kept here for its error word.
                    i_reg   <= (CW'(s_node_index) >= eff) ? CW'(s_node_index) : CW'(1);
                    if (CW'(s_node_index) >= eff) st_reg <= C_ERR;
                    else if (s_req_type == tpd_pkg::REQ_PUBLISH)
                        st_reg <= (eff > CW'(1)) ? C_SUM_RD : C_CLOSE_RD;
                end
                C_ERR: st_reg <= C_IDLE;
                C_SUM_RD: st_reg <= C_SUM_WAIT;
                C_SUM_WAIT: if (sts.seg_done) begin
                    if (i_reg + 1'b1 == cnt_reg) st_reg <= C_CLOSE_RD;
                    else begin
                        i_reg  <= i_reg + 1'b1;
                        st_reg <= C_SUM_RD;
                    end
                end
                C_CLOSE_RD: st_reg <= C_CLOSE_WAIT;
                C_CLOSE_WAIT: if (sts.seg_done) begin
                    i_reg  <= '0;
                    st_reg <= C_OUT_RD;
                end
                C_OUT_RD: st_reg <= C_OUT_WAIT;
                C_OUT_WAIT: begin
                    if (sts.seg_done && !lat_reg) st_reg <= C_OUT_EMIT;
                end
                C_OUT_EMIT: if (!sts.out_busy) begin
                    if (i_reg + 1'b1 == cnt_reg) st_reg <= C_IDLE;
                    else begin
                        i_reg  <= i_reg + 1'b1;
                        st_reg <= C_OUT_RD;
                    end
                end
                default: st_reg <= C_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/track_polyline_distance_table_core.sv =====
// Track polyline distance table: top level joining controller and datapath.
// Depends on tpd_pkg, tpd_ctrl and tpd_dp.
//
// A store-only word leaves the controller idle, so the next word can follow
// on the next edge unless the output register is stalled. An out-of-range
// index moves the controller to C_ERR, which loads its error word into the
// output register. A publish with N nodes walks the nodes twice, once to
// sum the loop length and once to emit each entry; every segment runs through
// one shared square root unit that resolves one root bit per cycle, and a
// publish also waits on output stalls, during which no word is accepted. A
// single-node table reports a total of zero.
module track_polyline_distance_table_core #(
    parameter int MAX_NODES     = tpd_pkg::MAX_NODES_DEF,
    parameter int POS_FRAC_BITS = tpd_pkg::POS_FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [tpd_pkg::CNT_W-1:0] cfg_data,
    input  logic s_valid,
    output logic s_ready,
    input  logic s_req_type,
    input  logic [tpd_pkg::IDX_W-1:0] s_node_index,
    input  logic signed [tpd_pkg::POS_W-1:0] s_pos_x,
    input  logic signed [tpd_pkg::POS_W-1:0] s_pos_y,
    input  logic signed [tpd_pkg::POS_W-1:0] s_pos_z,
    output logic m_valid,
    input  logic m_ready,
    output logic [tpd_pkg::IDX_W-1:0] m_out_index,
    output logic signed [tpd_pkg::QUANT_W-1:0] m_quant_x,
    output logic signed [tpd_pkg::QUANT_W-1:0] m_quant_y,
    output logic signed [tpd_pkg::QUANT_W-1:0] m_quant_z,
    output logic [tpd_pkg::DIST_W-1:0] m_rail_distance,
    output logic [tpd_pkg::TOTAL_W-1:0] m_total_length,
    output logic m_status,
    output logic m_last
);
    logic [tpd_pkg::CNT_W-1:0] node_count_reg;
    tpd_pkg::tpd_cmd_t cmd;
    tpd_pkg::tpd_sts_t sts;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) node_count_reg <= tpd_pkg::NODE_COUNT_RST;
        else if (cfg_valid) node_count_reg <= cfg_data;
    end

    tpd_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_req_type, .s_node_index,
        .node_count(node_count_reg), .sts, .cmd
    );

    tpd_dp #(.MAX_NODES(MAX_NODES), .POS_FRAC_BITS(POS_FRAC_BITS)) u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .in_index(s_node_index), .in_x(s_pos_x), .in_y(s_pos_y), .in_z(s_pos_z),
        .m_valid, .m_ready, .m_out_index, .m_quant_x, .m_quant_y, .m_quant_z,
        .m_rail_distance, .m_total_length, .m_status, .m_last
    );
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for track_polyline_distance_table_core.
// Depends on tpd_pkg and the core; predicts every output word, error words included, from a model of the node table.
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic [tpd_pkg::IDX_W-1:0]          idx;
        logic signed [tpd_pkg::QUANT_W-1:0] qx;
        logic signed [tpd_pkg::QUANT_W-1:0] qy;
        logic signed [tpd_pkg::QUANT_W-1:0] qz;
        logic [tpd_pkg::DIST_W-1:0]         rdist;
        logic [tpd_pkg::TOTAL_W-1:0]        total;
        logic                               status;
        logic                               last;
    } entry_t;

    localparam int LIMIT = 10000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [tpd_pkg::CNT_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_req_type = 1'b0;
    logic [tpd_pkg::IDX_W-1:0] s_node_index = '0;
    logic signed [tpd_pkg::POS_W-1:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [tpd_pkg::IDX_W-1:0] m_out_index;
    logic signed [tpd_pkg::QUANT_W-1:0] m_quant_x, m_quant_y, m_quant_z;
    logic [tpd_pkg::DIST_W-1:0] m_rail_distance;
    logic [tpd_pkg::TOTAL_W-1:0] m_total_length;
    logic m_status, m_last;

    track_polyline_distance_table_core dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    logic signed [tpd_pkg::POS_W-1:0] node_x [64];
    logic signed [tpd_pkg::POS_W-1:0] node_y [64];
    logic signed [tpd_pkg::POS_W-1:0] node_z [64];
    logic [tpd_pkg::CNT_W-1:0] node_count;
    entry_t table_words [$];
    int errors = 0;
    int send_idle = 0;
    int recv_idle = 0;
    longint cycles = 0;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic void add_word(input entry_t e);
        table_words = {table_words, e};
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned segment(input int a, input int b);
        longint dx, dy;
        dx = longint'(node_x[a]) - longint'(node_x[b]);
        dy = longint'(node_y[a]) - longint'(node_y[b]);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return root_floor(dx * dx + dy * dy);
    endfunction

    function automatic logic [tpd_pkg::QUANT_W-1:0] to_eighths(
            input logic signed [tpd_pkg::POS_W-1:0] v);
        longint s, q;
        s = v;
        q = ((s < 0 ? -s : s) + 4) >>> 3;
        if (s < 0) q = -q;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    task automatic predict_table(input logic rt, input int idx,
                                 input logic signed [tpd_pkg::POS_W-1:0] x, y, z);
        int cnt, i;
        longint unsigned d, total, q;
        entry_t e;
        cnt = node_count > 64 ? 64 : node_count;
        if (idx >= cnt) begin
            e = '0;
            e.idx = tpd_pkg::IDX_W'(idx);
            e.status = 1'b1;
            e.last = 1'b1;
            add_word(e);
            return;
        end
        node_x[idx] = x;
        node_y[idx] = y;
        node_z[idx] = z;
        if (rt == tpd_pkg::REQ_STORE) return;
        d = 0;
        for (i = 1; i < cnt; i++) d += segment(i, i - 1);
        total = d;
        if (cnt > 1) total += segment(cnt - 1, 0);
        if (total > 64'hFFFFFFFF) total = 64'hFFFFFFFF;
        d = 0;
        for (i = 0; i < cnt; i++) begin
            if (i > 0) d += segment(i, i - 1);
            q = (d * 3 + 32) >> 6;
            e.idx = tpd_pkg::IDX_W'(i);
            e.qx = to_eighths(node_x[i]);
            e.qy = to_eighths(node_y[i]);
            e.qz = to_eighths(node_z[i]);
            e.rdist = q > 65535 ? 16'hFFFF : q[15:0];
            e.total = total[31:0];
            e.status = 1'b0;
            e.last = (i + 1 == cnt);
            add_word(e);
        end
    endtask

    // Result checker and receiver-side stalls.
    always @(posedge aclk) begin
        entry_t e;
        if (aresetn && m_valid && m_ready) begin
            if (table_words.size() == 0) begin
                report("unexpected word", m_out_index, -1);
            end else begin
                e = table_words.pop_front();
                if (m_out_index !== e.idx) report("out_index", m_out_index, e.idx);
                if (m_quant_x !== e.qx) report("quant_x", m_quant_x, e.qx);
                if (m_quant_y !== e.qy) report("quant_y", m_quant_y, e.qy);
                if (m_quant_z !== e.qz) report("quant_z", m_quant_z, e.qz);
                if (m_rail_distance !== e.rdist)
                    report("rail_distance", m_rail_distance, e.rdist);
                if (m_total_length !== e.total) report("total_length", m_total_length, e.total);
                if (m_status !== e.status) report("status", m_status, e.status);
                if (m_last !== e.last) report("last", m_last, e.last);
            end
        end
    end

    always @(negedge aclk) m_ready <= ($urandom_range(99) >= recv_idle);

    // Valid stays up after the accepting edge until the next falling edge,
    // where either the next word or an idle cycle replaces it.
    task automatic send_word(input logic rt, input int idx,
                             input logic signed [tpd_pkg::POS_W-1:0] x, y, z);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= rt;
        s_node_index <= tpd_pkg::IDX_W'(idx);
        s_pos_x <= x;
        s_pos_y <= y;
        s_pos_z <= z;
        predict_table(rt, idx, x, y, z);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (table_words.size() != 0) @(negedge aclk);
        // A store-only word leaves nothing to wait on; give the core time to finish.
        repeat (50) @(negedge aclk);
    endtask

    task automatic write_count(input int n);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= tpd_pkg::CNT_W'(n);
        do @(posedge aclk); while (!cfg_ready);
        node_count = tpd_pkg::CNT_W'(n);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [tpd_pkg::POS_W-1:0] rand_pos();
        case ($urandom_range(4))
            0: return 24'sh7FFFFF;
            1: return -24'sh800000;
            2: return tpd_pkg::POS_W'($urandom_range(2047) - 1024);
            default: return tpd_pkg::POS_W'($urandom());
        endcase
    endfunction

    task automatic test_reset_table;
        // Full table of zeros at the reset count, then a publish of a far node.
        send_word(tpd_pkg::REQ_PUBLISH, 63, 24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF);
    endtask

    task automatic test_directed;
        write_count(4);
        send_word(tpd_pkg::REQ_STORE, 0, -24'sh800000, -24'sh800000, -24'sh800000);
        send_word(tpd_pkg::REQ_STORE, 1, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        send_word(tpd_pkg::REQ_STORE, 2, 4, -4, 12);
        send_word(tpd_pkg::REQ_PUBLISH, 3, -4, 3, -12);
        send_word(tpd_pkg::REQ_STORE, 4, 1, 1, 1);
        send_word(tpd_pkg::REQ_PUBLISH, 63, 1, 1, 1);
        write_count(1);
        send_word(tpd_pkg::REQ_PUBLISH, 0, 100, 200, 300);
        send_word(tpd_pkg::REQ_PUBLISH, 1, 0, 0, 0);
        write_count(0);
        send_word(tpd_pkg::REQ_PUBLISH, 0, 5, 5, 5);
        send_word(tpd_pkg::REQ_STORE, 0, 5, 5, 5);
        write_count(127);
        send_word(tpd_pkg::REQ_STORE, 42, 24'h555555, 24'hAAAAAA, 24'h555555);
        send_word(tpd_pkg::REQ_PUBLISH, 21, 24'hAAAAAA, 24'h555555, 24'hAAAAAA);
    endtask

    task automatic test_random_tracks(input int items);
        int n, k;
        for (k = 0; k < items; k++) begin
            if (k % 40 == 0) begin
                case ($urandom_range(5))
                    0: n = 64;
                    1: n = 1;
                    2: n = 2;
                    default: n = $urandom_range(8, 2);
                endcase
                write_count(n);
            end
            if ($urandom_range(9) == 0) begin
                send_word(1'($urandom_range(1)), $urandom_range(63), rand_pos(), rand_pos(),
                          rand_pos());
            end else begin
                send_word($urandom_range(3) == 0, $urandom_range(node_count > 64 ? 63 :
                          node_count - 1), rand_pos(), rand_pos(), rand_pos());
            end
        end
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < 64; i++) begin
            node_x[i] = '0;
            node_y[i] = '0;
            node_z[i] = '0;
        end
        node_count = tpd_pkg::NODE_COUNT_RST;
        send_idle = 6;
        recv_idle = 53;
        test_reset_table();
        test_directed();
        test_random_tracks(90);
        send_idle = 53;
        recv_idle = 6;
        test_random_tracks(90);
        send_idle = 0;
        recv_idle = 0;
        test_random_tracks(80);
        drain();
        if (errors == 0 && table_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
